### rtl/rice_pkg.sv
// Shared types and codes for the row int column extractor.
package rice_pkg;

	localparam int unsigned COL_W   = 5;
	localparam int unsigned NULL_W  = 32;
	localparam int unsigned VALUE_W = 32;

	typedef enum logic [1:0] {
		ST_FOUND = 2'd0,
		ST_NULL  = 2'd1,
		ST_BAD   = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		TY_INT     = 2'd0,
		TY_FLOAT   = 2'd1,
		TY_BOOL    = 2'd2,
		TY_VARCHAR = 2'd3
	} col_type_t;

	typedef enum logic [1:0] {
		REG_COLUMN_COUNT  = 2'd0,
		REG_TARGET_COLUMN = 2'd1,
		REG_COLUMN_TYPES  = 2'd2
	} reg_index_t;

	// outcome of skipping forward to the next non-null column
	typedef struct packed {
		logic             hit;
		status_t          status;
		logic [COL_W-1:0] col;
		col_type_t        ty;
	} seek_res_t;

endpackage

### rtl/rice_seek.sv
// Finds the next non-null column from a start index and decides early outcomes.
module rice_seek (
	input  logic [rice_pkg::COL_W-1:0]  start,
	input  logic [rice_pkg::COL_W-1:0]  column_count,
	input  logic [3:0]                  target_column,
	input  logic [31:0]                 column_types,
	input  logic [rice_pkg::NULL_W-1:0] null_bits,
	output rice_pkg::seek_res_t         res
);

	logic [rice_pkg::NULL_W-1:0] cand;
	logic [rice_pkg::NULL_W-1:0] live;
	logic                        found;
	logic [rice_pkg::COL_W-1:0]  first;
	logic [rice_pkg::COL_W-1:0]  tgt;
	logic                        tgt_null;
	rice_pkg::col_type_t         ty;

	always_comb begin
		for (int i = 0; i < rice_pkg::NULL_W; i++) begin
			cand[i] = (rice_pkg::COL_W'(i) >= start) && (rice_pkg::COL_W'(i) < column_count);
			live[i] = cand[i] && !null_bits[i];
		end
		found = 1'b0;
		first = '0;
		for (int i = rice_pkg::NULL_W - 1; i >= 0; i--) begin
			if (live[i]) begin
				found = 1'b1;
				first = rice_pkg::COL_W'(i);
			end
		end
	end

	assign tgt      = {1'b0, target_column};
	assign tgt_null = cand[tgt] && null_bits[tgt] && (!found || (first > tgt));
	assign ty       = first[4] ? rice_pkg::TY_INT
		: rice_pkg::col_type_t'(column_types[{first[3:0], 1'b0} +: 2]);

	always_comb begin
		res.hit    = 1'b0;
		res.status = rice_pkg::ST_BAD;
		res.col    = first;
		res.ty     = ty;
		if (tgt_null) begin
			res.status = rice_pkg::ST_NULL;
		end else if (!found) begin
			res.status = rice_pkg::ST_BAD;
		end else if ((first == tgt) && (ty != rice_pkg::TY_INT)) begin
			res.status = rice_pkg::ST_BAD;
		end else begin
			res.hit = 1'b1;
		end
	end

endmodule

### rtl/row_int_column_extractor_top.sv
// Top level of the row int column extractor: row parser, config registers, output register.
//
//  channel  | dir | handshake                    | word
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: row_byte; tlast: row_last
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: column_value; tuser: status
//  cfg      | in  | cfg_valid/cfg_ready          | cfg_index, cfg_data
//
// One row byte per cycle; the parse step plus the column skip search sits between
// the row state registers and the output register. A result appears on m_axis
// the cycle after the byte that decides it. s_axis_tready drops only while a
// result waits in the output register and m_axis_tready is low. arst_n clears
// row state and sets the config registers to defaults.
module row_int_column_extractor_top #(
	parameter int unsigned MAX_COLUMNS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] row_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] column_value
	output logic [1:0]  m_axis_tuser,   // [1:0] status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	typedef enum logic [1:0] {
		PH_BITMAP,
		PH_FIELD,
		PH_LEN,
		PH_DONE
	} phase_t;

	localparam int unsigned CW = rice_pkg::COL_W;

	logic [CW-1:0]  column_count_q;
	logic [3:0]     target_column_q;
	logic [31:0]    column_types_q;

	phase_t                          phase_q, phase_n;
	logic [15:0]                     pos_q, pos_n;
	logic [CW-1:0]                   col_q, col_n;
	logic [16:0]                     left_q, left_n;
	logic [rice_pkg::NULL_W-1:0]     null_q, null_n;
	logic [rice_pkg::VALUE_W-1:0]    val_q, val_n;
	logic [15:0]                     len_q, len_n;

	logic                            out_valid_q;
	logic [31:0]                     out_value_q;
	rice_pkg::status_t               out_status_q;

	logic                            acc;
	logic                            emit;
	rice_pkg::status_t               st;
	logic [31:0]                     res_value;
	logic [CW-1:0]                   col_step;
	logic [CW-1:0]                   seek_start;
	logic                            tgt_here;
	logic [2:0]                      nbytes;
	logic [1:0]                      fsh;
	rice_pkg::seek_res_t             seek;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_value_q;
	assign m_axis_tuser  = out_status_q;

	assign col_step   = col_q + CW'(1);
	assign seek_start = (phase_q == PH_BITMAP) ? '0 : col_step;
	assign tgt_here   = (col_q == {1'b0, target_column_q});
	assign nbytes     = 3'(({1'b0, column_count_q} + 6'd7) >> 3);
	assign fsh        = 2'(3'd4 - left_q[2:0]);

	rice_seek u_seek (
		.start         (seek_start),
		.column_count  (column_count_q),
		.target_column (target_column_q),
		.column_types  (column_types_q),
		.null_bits     (null_n),
		.res           (seek)
	);

	always_comb begin
		phase_n = phase_q;
		pos_n   = pos_q;
		col_n   = col_q;
		left_n  = left_q;
		null_n  = null_q;
		val_n   = val_q;
		len_n   = len_q;
		emit    = 1'b0;
		st      = rice_pkg::ST_BAD;
		case (phase_q)
			PH_BITMAP: begin
				if ((pos_q == '0) && ({1'b0, target_column_q} >= column_count_q)) begin
					emit = 1'b1;
					st   = rice_pkg::ST_RANGE;
				end else if ((pos_q == '0) && ({1'b0, column_count_q} > 6'(MAX_COLUMNS))) begin
					emit = 1'b1;
					st   = rice_pkg::ST_BAD;
				end else begin
					if (pos_q < 16'd4) begin
						null_n = null_q | (32'(s_axis_tdata) << {pos_q[1:0], 3'b000});
					end
					pos_n = (pos_q == 16'hFFFF) ? pos_q : pos_q + 16'd1;
					if (pos_n >= 16'(nbytes)) begin
						col_n = '0;
						if (seek.hit) begin
							col_n = seek.col;
							val_n = '0;
							len_n = '0;
							if (seek.ty == rice_pkg::TY_VARCHAR) begin
								left_n  = 17'd2;
								phase_n = PH_LEN;
							end else begin
								left_n  = (seek.ty == rice_pkg::TY_BOOL) ? 17'd1 : 17'd4;
								phase_n = PH_FIELD;
							end
						end else begin
							emit = 1'b1;
							st   = seek.status;
						end
					end
				end
			end
			PH_FIELD: begin
				if ((left_q >= 17'd1) && (left_q <= 17'd4) && tgt_here) begin
					val_n = val_q | (32'(s_axis_tdata) << {fsh, 3'b000});
				end
				left_n = (left_q != '0) ? left_q - 17'd1 : left_q;
				if (left_n == '0) begin
					if (tgt_here) begin
						emit = 1'b1;
						st   = rice_pkg::ST_FOUND;
					end else if (col_step == '0) begin
						emit = 1'b1;
						st   = rice_pkg::ST_BAD;
					end else if (seek.hit) begin
						col_n = seek.col;
						val_n = '0;
						len_n = '0;
						if (seek.ty == rice_pkg::TY_VARCHAR) begin
							left_n  = 17'd2;
							phase_n = PH_LEN;
						end else begin
							left_n  = (seek.ty == rice_pkg::TY_BOOL) ? 17'd1 : 17'd4;
							phase_n = PH_FIELD;
						end
					end else begin
						emit = 1'b1;
						st   = seek.status;
					end
				end
			end
			PH_LEN: begin
				if ((left_q >= 17'd1) && (left_q <= 17'd2)) begin
					len_n = len_q | (16'(s_axis_tdata) << {left_q[0], 3'b000});
				end
				left_n = (left_q != '0) ? left_q - 17'd1 : left_q;
				if (left_n == '0) begin
					if (len_n != '0) begin
						left_n  = 17'(len_n);
						phase_n = PH_FIELD;
					end else if (col_step == '0) begin
						emit = 1'b1;
						st   = rice_pkg::ST_BAD;
					end else if (seek.hit) begin
						col_n = seek.col;
						val_n = '0;
						len_n = '0;
						if (seek.ty == rice_pkg::TY_VARCHAR) begin
							left_n  = 17'd2;
							phase_n = PH_LEN;
						end else begin
							left_n  = (seek.ty == rice_pkg::TY_BOOL) ? 17'd1 : 17'd4;
							phase_n = PH_FIELD;
						end
					end else begin
						emit = 1'b1;
						st   = seek.status;
					end
				end
			end
			default: begin
			end
		endcase
		if (emit) begin
			phase_n = PH_DONE;
		end
		res_value = (emit && (st == rice_pkg::ST_FOUND)) ? val_n : '0;
		// short row: last byte with no result yet
		if (s_axis_tlast && (phase_n != PH_DONE)) begin
			emit      = 1'b1;
			st        = rice_pkg::ST_BAD;
			res_value = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q  <= CW'(1);
			target_column_q <= '0;
			column_types_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rice_pkg::REG_COLUMN_COUNT:  column_count_q  <= cfg_data[CW-1:0];
				rice_pkg::REG_TARGET_COLUMN: target_column_q <= cfg_data[3:0];
				rice_pkg::REG_COLUMN_TYPES:  column_types_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BITMAP;
			pos_q   <= '0;
			col_q   <= '0;
			left_q  <= '0;
			null_q  <= '0;
			val_q   <= '0;
			len_q   <= '0;
		end else if (acc) begin
			if (s_axis_tlast) begin
				phase_q <= PH_BITMAP;
				pos_q   <= '0;
				col_q   <= '0;
				left_q  <= '0;
				null_q  <= '0;
				val_q   <= '0;
				len_q   <= '0;
			end else begin
				phase_q <= phase_n;
				pos_q   <= pos_n;
				col_q   <= col_n;
				left_q  <= left_n;
				null_q  <= null_n;
				val_q   <= val_n;
				len_q   <= len_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && emit) begin
			out_value_q  <= res_value;
			out_status_q <= st;
		end
	end

endmodule

### rtl/rice_chk.sv
// Port-level checker for the row int column extractor, bound to the top level.
module rice_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	a_ready_only_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without a pending result");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != rice_pkg::ST_FOUND) |-> m_axis_tdata == '0)
		else $error("non-zero value with a non-found status");

	a_ready_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready |-> s_axis_tready)
		else $error("input not ready while result is taken");

endmodule

bind row_int_column_extractor_top rice_chk u_rice_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

### dv/row_int_column_extractor_checker.sv
// Checker for the row int column extractor: predicts one answer per row and compares m_axis words.
module row_int_column_extractor_checker #(
	parameter int unsigned MAX_COLS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,
	input  logic [1:0]  m_axis_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          mismatches,
	output int          pending
);

	typedef enum logic [1:0] {
		P_NULLMAP,
		P_FIXED,
		P_VARLEN,
		P_SKIP
	} parse_phase_t;

	typedef struct {
		logic [31:0]       value;
		rice_pkg::status_t status;
	} answer_t;

	localparam int NO_ANSWER = -1;

	logic [4:0]   col_count_cfg;
	logic [3:0]   target_cfg;
	logic [31:0]  types_cfg;

	logic [15:0]  map_pos;
	logic [4:0]   col_idx;
	logic [16:0]  field_left;
	logic [31:0]  null_mask;
	logic [31:0]  value_acc;
	logic [15:0]  len_acc;
	parse_phase_t phase;
	logic         answered;

	answer_t      answers[$];

	function automatic void clear_row();
		map_pos    = '0;
		col_idx    = '0;
		field_left = '0;
		null_mask  = '0;
		value_acc  = '0;
		len_acc    = '0;
		phase      = P_NULLMAP;
		answered   = 1'b0;
	endfunction

	// skip nulls up to the next present column and set up its field
	function automatic int seek_column();
		rice_pkg::col_type_t ty;
		while (col_idx < col_count_cfg) begin
			if (null_mask[col_idx]) begin
				if (col_idx == target_cfg)
					return rice_pkg::ST_NULL;
				col_idx = col_idx + 5'd1;
				if (col_idx == 5'd0)
					return rice_pkg::ST_BAD;
				continue;
			end
			ty = (col_idx < 16) ? rice_pkg::col_type_t'(types_cfg[2*col_idx +: 2])
				: rice_pkg::TY_INT;
			if (col_idx == target_cfg && ty != rice_pkg::TY_INT)
				return rice_pkg::ST_BAD;
			value_acc = '0;
			len_acc   = '0;
			if (ty == rice_pkg::TY_VARCHAR) begin
				field_left = 17'd2;
				phase      = P_VARLEN;
			end else begin
				field_left = (ty == rice_pkg::TY_BOOL) ? 17'd1 : 17'd4;
				phase      = P_FIXED;
			end
			return NO_ANSWER;
		end
		return rice_pkg::ST_BAD;
	endfunction

	function automatic int next_column();
		col_idx = col_idx + 5'd1;
		if (col_idx == 5'd0)
			return rice_pkg::ST_BAD;
		return seek_column();
	endfunction

	task automatic predict_byte(input logic [7:0] b, input logic last);
		int st;
		int map_bytes;
		st = NO_ANSWER;
		case (phase)
			P_NULLMAP: begin
				if (map_pos == 16'd0) begin
					if (target_cfg >= col_count_cfg)
						st = rice_pkg::ST_RANGE;
					else if (col_count_cfg > MAX_COLS)
						st = rice_pkg::ST_BAD;
				end
				if (st == NO_ANSWER) begin
					map_bytes = (int'(col_count_cfg) + 7) / 8;
					if (map_pos < 16'd4)
						null_mask |= 32'(b) << (8 * map_pos);
					if (map_pos != 16'hFFFF)
						map_pos++;
					if (map_pos >= map_bytes) begin
						col_idx = '0;
						st = seek_column();
					end
				end
			end
			P_FIXED: begin
				if (field_left >= 1 && field_left <= 4 && col_idx == target_cfg)
					value_acc |= 32'(b) << (8 * ((4 - int'(field_left)) & 3));
				if (field_left > 0)
					field_left--;
				if (field_left == 0) begin
					if (col_idx == target_cfg)
						st = rice_pkg::ST_FOUND;
					else
						st = next_column();
				end
			end
			P_VARLEN: begin
				if (field_left >= 1 && field_left <= 2)
					len_acc |= 16'(b) << (8 * ((2 - int'(field_left)) & 1));
				if (field_left > 0)
					field_left--;
				if (field_left == 0) begin
					if (len_acc == 16'd0) begin
						st = next_column();
					end else begin
						field_left = 17'(len_acc);
						phase      = P_FIXED;
					end
				end
			end
			default: ;
		endcase
		if (st != NO_ANSWER && !answered) begin
			answers.push_back(answer_t'{(st == rice_pkg::ST_FOUND) ? value_acc : 32'd0,
				rice_pkg::status_t'(st[1:0])});
			answered = 1'b1;
			phase    = P_SKIP;
		end
		if (last) begin
			if (!answered)
				answers.push_back(answer_t'{32'd0, rice_pkg::ST_BAD});
			clear_row();
		end
	endtask

	task automatic check_word();
		answer_t exp;
		if (answers.size() == 0) begin
			$error("unexpected word: column_value %0d status %0d",
				$signed(m_axis_tdata), m_axis_tuser);
			mismatches++;
		end else begin
			exp = answers.pop_front();
			if (m_axis_tdata !== exp.value) begin
				$error("column_value: expected %0d, actual %0d",
					$signed(exp.value), $signed(m_axis_tdata));
				mismatches++;
			end
			if (m_axis_tuser !== exp.status) begin
				$error("status: expected %0d, actual %0d", exp.status, m_axis_tuser);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_cfg = 5'd1;
			target_cfg    = '0;
			types_cfg     = '0;
			clear_row();
			answers.delete();
			mismatches = 0;
			pending    = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_word();
			if (s_axis_tvalid && s_axis_tready)
				predict_byte(s_axis_tdata, s_axis_tlast);
			if (cfg_valid && cfg_ready) begin
				case (rice_pkg::reg_index_t'(cfg_index))
					rice_pkg::REG_COLUMN_COUNT:  col_count_cfg = cfg_data[4:0];
					rice_pkg::REG_TARGET_COLUMN: target_cfg    = cfg_data[3:0];
					rice_pkg::REG_COLUMN_TYPES:  types_cfg     = cfg_data;
					default: ;
				endcase
			end
			pending = answers.size();
		end
	end

endmodule

### dv/row_int_column_extractor_top_tb.sv
// Testbench top for the row int column extractor: row stimulus, flow control and verdict.
module row_int_column_extractor_top_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_BYTES = 40;
	localparam int HOLD_CYCLES = 150;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	int          mismatches;
	int          pending;
	int          sent_bytes = 0;
	int          cycles = 0;
	int          hold_left = 0;
	bit          held = 1'b0;

	logic [4:0]  cur_count;
	logic [31:0] cur_types;
	logic [7:0]  row_q[$];

	row_int_column_extractor_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	row_int_column_extractor_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("row_int_column_extractor_top_tb failed");
			$finish;
		end
	end

	// receiver: idles heavily first, lightly next, then never; one long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!held && sent_bytes >= 760) begin
			held <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= $urandom_range(0, 99) >=
				((sent_bytes < 320) ? 77 : (sent_bytes < 640) ? 7 : 0);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < ((sent_bytes < 320) ? 7 : (sent_bytes < 640) ? 77 : 0)) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		sent_bytes++;
		@(negedge clk);
	endtask

	task automatic send_row();
		int k;
		for (k = 0; k < row_q.size(); k++)
			send_byte(row_q[k], k == row_q.size() - 1);
	endtask

	task automatic write_reg(input rice_pkg::reg_index_t idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_word();
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: return 32'h0000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h8000_0000;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		return $urandom;
	endfunction

	// mostly well-formed rows with random content, some cut short, some pure noise
	function automatic void build_row();
		int kind;
		int map_bytes;
		int col;
		int len;
		int k;
		int cut;
		logic [31:0] nulls;
		logic [31:0] word;
		rice_pkg::col_type_t ty;
		row_q.delete();
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			repeat ($urandom_range(1, 10)) row_q.push_back(8'($urandom));
			return;
		end
		map_bytes = (int'(cur_count) + 7) / 8;
		if (map_bytes == 0)
			map_bytes = 1;
		nulls = ($urandom_range(0, 3) == 0) ? 32'd0 : ($urandom & $urandom);
		for (k = 0; k < map_bytes; k++)
			row_q.push_back(nulls[8*k +: 8]);
		for (col = 0; col < cur_count; col++) begin
			if (nulls[col])
				continue;
			ty = (col < 16) ? rice_pkg::col_type_t'(cur_types[2*col +: 2]) : rice_pkg::TY_INT;
			case (ty)
				rice_pkg::TY_INT, rice_pkg::TY_FLOAT: begin
					word = pick_word();
					for (k = 0; k < 4; k++)
						row_q.push_back(word[8*k +: 8]);
				end
				rice_pkg::TY_BOOL: row_q.push_back(8'($urandom));
				default: begin
					len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535)
						: $urandom_range(0, 6);
					row_q.push_back(len[7:0]);
					row_q.push_back(len[15:8]);
					if (len > 40) begin
						repeat ($urandom_range(0, 8)) row_q.push_back(8'($urandom));
						return;
					end
					repeat (len) row_q.push_back(8'($urandom));
				end
			endcase
		end
		repeat ($urandom_range(0, 2)) row_q.push_back(8'($urandom));
		if (kind < 27) begin
			cut = $urandom_range(1, row_q.size());
			while (row_q.size() > cut)
				void'(row_q.pop_back());
		end
	endfunction

	task automatic run_phase(input logic [4:0] count, input logic [3:0] target,
			input logic [31:0] types);
		int start;
		start = sent_bytes;
		write_reg(rice_pkg::REG_COLUMN_COUNT, 32'(count));
		write_reg(rice_pkg::REG_TARGET_COLUMN, 32'(target));
		write_reg(rice_pkg::REG_COLUMN_TYPES, types);
		cfg_valid <= 1'b0;
		cur_count  = count;
		cur_types  = types;
		while (sent_bytes - start < PHASE_BYTES) begin
			build_row();
			send_row();
		end
		s_axis_tvalid <= 1'b0;
		drain();
	endtask

	function automatic logic [31:0] types_with_int(input logic [3:0] target);
		logic [31:0] t;
		t = $urandom;
		if ($urandom_range(0, 3) != 0)
			t[2*target +: 2] = rice_pkg::TY_INT;
		return t;
	endfunction

	initial begin
		logic [4:0] count;
		logic [3:0] target;
		int n;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = rice_pkg::REG_COLUMN_COUNT;
		cfg_data      = '0;
		cur_count     = 5'd1;
		cur_types     = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// default schema: one int column
		row_q = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_row();
		row_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h80};
		send_row();
		row_q = '{8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hAA};
		send_row();
		row_q = '{8'h01, 8'h55};
		send_row();
		row_q = '{8'h00, 8'h12, 8'h34};
		send_row();
		s_axis_tvalid <= 1'b0;
		drain();

		run_phase(5'd16, 4'd15, types_with_int(4'd15));
		run_phase(5'd1, 4'd0, 32'hFFFF_FFFF);
		run_phase(5'd31, 4'd15, 32'h0);
		run_phase(5'd0, 4'd0, 32'h0);
		run_phase(5'd5, 4'd12, $urandom);
		run_phase(5'd16, 4'd15, 32'h3FFF_FFFF);
		run_phase(5'd9, 4'd8, types_with_int(4'd8));
		run_phase(5'd8, 4'd7, 32'h0);
		for (n = 0; n < 10; n++) begin
			count  = 5'($urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(1, 16));
			target = 4'($urandom_range(0, int'(count) - 1));
			run_phase(count, target, types_with_int(target));
		end

		drain();
		repeat (6) @(negedge clk);
		if (mismatches == 0)
			$display("row_int_column_extractor_top_tb passed");
		else
			$display("row_int_column_extractor_top_tb failed");
		$finish;
	end

endmodule
